### design/imhq_pkg.sv
`timescale 1ns / 1ps

package imhq_pkg;

  localparam int ELEM_W   = 9;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

endpackage

### design/imhq_ram.sv
`timescale 1ns / 1ps

module imhq_ram #(
  parameter int DEPTH = 257,
  parameter int WIDTH = 41,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/indexed_min_heap_queue_top.sv
`timescale 1ns / 1ps

// Indexed binary min-heap of element numbers with signed fixed-point
// priorities. Heap slots and the element-to-position map each live in a
// one-port-read, one-port-write memory with registered read, and a sequencer
// walks them one access at a time. Each level climbed on insert or a lowered
// priority takes a parent read and a compare, and each level descended on
// remove or a raised priority takes two child reads and a compare. The worst
// case is a raised priority at the root of a full 256-entry heap sinking
// eight levels. The next item is taken at the edge after the previous result
// is loaded into the output register; a stalled result holds the input off.
// After reset the position map is cleared one entry per cycle
// (MAX_ELEMENTS + 1 entries, capped at 512) before the first item is taken.
module indexed_min_heap_queue_top #(
  parameter int MAX_ELEMENTS   = 256,
  parameter int PRIORITY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [imhq_pkg::ELEM_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_mode,
  input  logic [imhq_pkg::ELEM_W-1:0]      in_element,
  input  logic signed [PRIORITY_WIDTH-1:0] in_priority_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [imhq_pkg::STATUS_W-1:0]    out_status,
  output logic [imhq_pkg::COUNT_W-1:0]     out_count,
  output logic [imhq_pkg::ELEM_W-1:0]      out_top_element,
  output logic signed [PRIORITY_WIDTH-1:0] out_top_priority,
  output logic                             out_found,
  output logic signed [PRIORITY_WIDTH-1:0] out_found_priority
);

  localparam int EW        = imhq_pkg::ELEM_W;
  localparam int PW        = PRIORITY_WIDTH;
  localparam int HW        = EW + PW;
  localparam int POS_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int MAP_DEPTH = (MAX_ELEMENTS < 511 ? MAX_ELEMENTS : 511) + 1;
  localparam int MAP_W     = $clog2(MAP_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_LOOK, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP,
    S_RM_ROOT, S_RM_LAST, S_FIN, S_TOP_RD, S_TOP_CAP, S_DONE
  } state_t;

  state_t                   state_r;
  logic                     clr_r;
  logic [MAP_W-1:0]         clr_idx_r;
  logic [EW-1:0]            range_r;
  logic [POS_W-1:0]         count_r;
  logic [POS_W-1:0]         pos_r;
  imhq_pkg::mode_t          mode_r;
  logic [EW-1:0]            cur_elem_r;
  logic signed [PW-1:0]     cur_prio_r;
  logic [EW-1:0]            left_elem_r;
  logic signed [PW-1:0]     left_prio_r;
  logic                     has_right_r;
  logic [imhq_pkg::STATUS_W-1:0] status_r;
  logic                     found_r;
  logic signed [PW-1:0]     fprio_r;
  logic [EW-1:0]            top_elem_r;
  logic signed [PW-1:0]     top_prio_r;

  logic                     h_we;
  logic [POS_W-1:0]         h_wa, h_ra;
  logic [HW-1:0]            h_wd, h_rd;
  logic                     m_we;
  logic [MAP_W-1:0]         m_wa, m_ra;
  logic [POS_W-1:0]         m_wd, m_rd;

  logic [EW-1:0]            rd_elem;
  logic signed [PW-1:0]     rd_prio;
  logic [POS_W:0]           child, child1, cnt_x;
  logic                     take_right;
  logic [EW-1:0]            sel_elem;
  logic signed [PW-1:0]     sel_prio;
  logic [POS_W-1:0]         sel_pos;
  logic                     accept, in_range;

  assign rd_elem    = h_rd[HW-1 -: EW];
  assign rd_prio    = $signed(h_rd[PW-1:0]);
  assign child      = {pos_r, 1'b0};
  assign child1     = child + 1'b1;
  assign cnt_x      = {1'b0, count_r};
  assign take_right = has_right_r && (rd_prio < left_prio_r);
  assign sel_elem   = take_right ? rd_elem : left_elem_r;
  assign sel_prio   = take_right ? rd_prio : left_prio_r;
  assign sel_pos    = take_right ? child1[POS_W-1:0] : child[POS_W-1:0];
  assign in_stall   = (state_r != S_IDLE) || clr_r;
  assign accept     = in_valid && !in_stall;
  assign in_range   = (in_element != '0) && (in_element <= range_r) &&
                      (32'(in_element) <= 32'(MAX_ELEMENTS));

  imhq_ram #(.DEPTH(MAX_ELEMENTS + 1), .WIDTH(HW), .AW(POS_W)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  imhq_ram #(.DEPTH(MAP_DEPTH), .WIDTH(POS_W), .AW(MAP_W)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  always_comb begin
    h_we = 1'b0;
    h_wa = pos_r;
    h_wd = {cur_elem_r, cur_prio_r};
    h_ra = POS_W'(1);
    m_we = 1'b0;
    m_wa = cur_elem_r[MAP_W-1:0];
    m_wd = pos_r;
    m_ra = in_element[MAP_W-1:0];
    unique case (state_r)
      S_MAP:     h_ra = m_rd;
      S_UP_RD:   h_ra = pos_r >> 1;
      S_DN_RDL:  h_ra = child[POS_W-1:0];
      S_DN_RDR:  h_ra = child1[POS_W-1:0];
      S_RM_ROOT: begin
        h_ra = count_r;
        m_we = 1'b1;
        m_wa = rd_elem[MAP_W-1:0];
        m_wd = '0;
      end
      S_UP_CMP: begin
        if (rd_prio > cur_prio_r) begin
          h_we = 1'b1;
          h_wd = h_rd;
          m_we = 1'b1;
          m_wa = rd_elem[MAP_W-1:0];
        end
      end
      S_DN_CMP: begin
        if (!(cur_prio_r < sel_prio)) begin
          h_we = 1'b1;
          h_wd = {sel_elem, sel_prio};
          m_we = 1'b1;
          m_wa = sel_elem[MAP_W-1:0];
        end
      end
      S_FIN: begin
        h_we = 1'b1;
        m_we = 1'b1;
      end
      default: ;
    endcase
    if (clr_r) begin
      m_we = 1'b1;
      m_wa = clr_idx_r;
      m_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      range_r   <= EW'(256);
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == MAP_W'(MAP_DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        range_r <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state_r != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r     <= imhq_pkg::mode_t'(in_mode);
            cur_elem_r <= in_element;
            cur_prio_r <= in_priority_req;
            found_r    <= 1'b0;
            fprio_r    <= '0;
            if (imhq_pkg::mode_t'(in_mode) == imhq_pkg::MODE_REMOVE) begin
              if (count_r == '0) begin
                status_r <= imhq_pkg::ST_EMPTY;
                state_r  <= S_TOP_RD;
              end else begin
                status_r <= imhq_pkg::ST_OK;
                state_r  <= S_RM_ROOT;
              end
            end else if (!in_range) begin
              status_r <= imhq_pkg::ST_RANGE;
              state_r  <= S_TOP_RD;
            end else begin
              status_r <= imhq_pkg::ST_OK;
              state_r  <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (mode_r == imhq_pkg::MODE_INSERT) begin
            if (m_rd != '0) begin
              status_r <= imhq_pkg::ST_DUP;
              state_r  <= S_TOP_RD;
            end else begin
              count_r <= count_r + 1'b1;
              pos_r   <= count_r + 1'b1;
              state_r <= S_UP_RD;
            end
          end else if (m_rd == '0) begin
            status_r <= imhq_pkg::ST_ABSENT;
            state_r  <= S_TOP_RD;
          end else begin
            pos_r   <= m_rd;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (mode_r == imhq_pkg::MODE_LOOKUP) begin
            found_r <= 1'b1;
            fprio_r <= rd_prio;
            state_r <= S_TOP_RD;
          end else if (cur_prio_r < rd_prio) begin
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_DN_RDL;
          end
        end
        S_UP_RD: state_r <= (pos_r == POS_W'(1)) ? S_FIN : S_UP_CMP;
        S_UP_CMP: begin
          if (rd_prio > cur_prio_r) begin
            pos_r   <= pos_r >> 1;
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DN_RDL: state_r <= (child > cnt_x) ? S_FIN : S_DN_RDR;
        S_DN_RDR: begin
          left_elem_r <= rd_elem;
          left_prio_r <= rd_prio;
          has_right_r <= (child1 <= cnt_x);
          state_r     <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cur_prio_r < sel_prio) begin
            state_r <= S_FIN;
          end else begin
            pos_r   <= sel_pos;
            state_r <= S_DN_RDL;
          end
        end
        S_RM_ROOT: state_r <= S_RM_LAST;
        S_RM_LAST: begin
          if (count_r == POS_W'(1)) begin
            count_r <= '0;
            state_r <= S_TOP_RD;
          end else begin
            // The last entry fills the root hole and then sinks.
            cur_elem_r <= rd_elem;
            cur_prio_r <= rd_prio;
            count_r    <= count_r - 1'b1;
            pos_r      <= POS_W'(1);
            state_r    <= S_DN_RDL;
          end
        end
        S_FIN:    state_r <= S_TOP_RD;
        S_TOP_RD: state_r <= S_TOP_CAP;
        S_TOP_CAP: begin
          top_elem_r <= (count_r != '0) ? rd_elem : '0;
          top_prio_r <= (count_r != '0) ? rd_prio : '0;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_status         <= status_r;
            out_count          <= imhq_pkg::COUNT_W'(count_r);
            out_top_element    <= top_elem_r;
            out_top_priority   <= top_prio_r;
            out_found          <= found_r;
            out_found_priority <= fprio_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall)
    else $error("item taken during map clear");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_ELEMENTS))
    else $error("count above capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == imhq_pkg::ST_OK)
    else $error("found with failing status");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == '0) |-> (out_top_element == '0))
    else $error("empty queue shows a root");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (status_r != imhq_pkg::ST_OK) |-> $stable(count_r))
    else $error("rejected item changed count");

endmodule
